// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the sampler top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/cbs_pkg.sv =====
// types, constants and the operation schedule of the bezier sampler
package cbs_pkg;

    localparam int MAX_SAMPLES_DEF = 64;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int T_BITS          = 16;
    localparam int TV_W            = T_BITS + 1;
    localparam int CFG_W           = 7;
    localparam int CFG_RESET       = 10;
    localparam int IDX_OUT_W       = 6;
    localparam int NAXES           = 3;
    localparam int NOPS            = 11;
    localparam int STEP_W          = $clog2(NOPS + 1);
    localparam int DIV_STEPS       = T_BITS + 2;
    localparam int CNT_W           = $clog2(DIV_STEPS);

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COEF,
        S_DIV,
        S_MUL,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        A_T,
        A_T2,
        A_C,
        A_B,
        A_A
    } t_asel;

    typedef enum logic [1:0] {
        B_T,
        B_T2,
        B_T3
    } t_bsel;

    typedef enum logic [1:0] {
        D_T2,
        D_T3,
        D_ACC
    } t_dst;

    typedef struct packed {
        t_asel      asel;
        t_bsel      bsel;
        t_dst       dst;
        logic [1:0] axis;
    } t_op;

    // one multiply per step; a product is registered, then written back, before a later step can use it
    function automatic t_op op_of(logic [STEP_W-1:0] step);
        t_op op;
        unique case (step)
            4'd0:    op = '{A_T,  B_T,  D_T2,  AX_X};
            4'd1:    op = '{A_C,  B_T,  D_ACC, AX_X};
            4'd2:    op = '{A_T2, B_T,  D_T3,  AX_X};
            4'd3:    op = '{A_C,  B_T,  D_ACC, AX_Y};
            4'd4:    op = '{A_A,  B_T3, D_ACC, AX_X};
            4'd5:    op = '{A_C,  B_T,  D_ACC, AX_Z};
            4'd6:    op = '{A_B,  B_T2, D_ACC, AX_X};
            4'd7:    op = '{A_B,  B_T2, D_ACC, AX_Y};
            4'd8:    op = '{A_B,  B_T2, D_ACC, AX_Z};
            4'd9:    op = '{A_A,  B_T3, D_ACC, AX_Y};
            4'd10:   op = '{A_A,  B_T3, D_ACC, AX_Z};
            default: op = '{A_T,  B_T,  D_T2,  AX_X};
        endcase
        return op;
    endfunction

endpackage

// ===== hw/rtl/cbs_pts_if.sv =====
// control point channel: one bezier segment per beat
interface cbs_pts_if #(
    parameter int COORD_WIDTH = cbs_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] start_z;
    logic signed [COORD_WIDTH-1:0] ctrl1_x;
    logic signed [COORD_WIDTH-1:0] ctrl1_y;
    logic signed [COORD_WIDTH-1:0] ctrl1_z;
    logic signed [COORD_WIDTH-1:0] ctrl2_x;
    logic signed [COORD_WIDTH-1:0] ctrl2_y;
    logic signed [COORD_WIDTH-1:0] ctrl2_z;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic signed [COORD_WIDTH-1:0] end_z;

    modport source (
        output valid, start_x, start_y, start_z, ctrl1_x, ctrl1_y, ctrl1_z,
               ctrl2_x, ctrl2_y, ctrl2_z, end_x, end_y, end_z,
        input  ready
    );

    modport sink (
        input  valid, start_x, start_y, start_z, ctrl1_x, ctrl1_y, ctrl1_z,
               ctrl2_x, ctrl2_y, ctrl2_z, end_x, end_y, end_z,
        output ready
    );
endinterface

// ===== hw/rtl/cbs_smp_if.sv =====
// sample channel: one curve point per beat
interface cbs_smp_if #(
    parameter int COORD_WIDTH = cbs_pkg::COORD_WIDTH_DEF
);
    logic                              valid;
    logic                              ready;
    logic signed [COORD_WIDTH-1:0]     point_x;
    logic signed [COORD_WIDTH-1:0]     point_y;
    logic signed [COORD_WIDTH-1:0]     point_z;
    logic [cbs_pkg::IDX_OUT_W-1:0]     sample_index;
    logic                              last_sample;

    modport source (
        output valid, point_x, point_y, point_z, sample_index, last_sample,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, point_z, sample_index, last_sample,
        output ready
    );
endinterface

// ===== hw/rtl/cubic_bezier_sampler_3d_top.sv =====
// cubic bezier sampler, three axes, one shared multiplier
//
// i_pts takes one segment per beat (start, two controls, end, signed fixed
// point). o_smp gives samples_per_curve points of the segment for t evenly
// spaced over 0..1, in order of index, the final one flagged last_sample.
// i_cfg_we / i_cfg_wdata set samples_per_curve (clamped to 2..MAX_SAMPLES),
// which the user must write only while no segment is in flight; the block
// does not enforce this. Reset sets it to 10.
//
// A segment goes through coefficient setup and the t step division (one
// quotient bit a cycle), then per sample eleven multiplies issued back to
// back on the one multiplier, a drain step and the output register load.
// i_pts.ready is high only between segments; it rises once the last sample
// sits in the output register, so the next segment is taken while it waits.
// A stalled receiver holds the output register; the sequencer then waits
// with the next sample finished. Reset empties the output register and
// returns the sequencer to idle.
`include "assert_macros.svh"

module cubic_bezier_sampler_3d_top #(
    parameter int MAX_SAMPLES = cbs_pkg::MAX_SAMPLES_DEF,
    parameter int COORD_WIDTH = cbs_pkg::COORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [cbs_pkg::CFG_W-1:0]   i_cfg_wdata,
    cbs_pts_if.sink                     i_pts,
    cbs_smp_if.source                   o_smp
);
    import cbs_pkg::*;

    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam int D_W   = IDX_W + 1;
    localparam int R_W   = IDX_W + 2;
    localparam int DF_W  = COORD_WIDTH + 1;
    localparam int CF_W  = COORD_WIDTH + 4;
    localparam int PR_W  = CF_W + TV_W + 1;
    localparam int ACC_W = CF_W + 2;

    localparam logic [CFG_W-1:0] MAXN = CFG_W'(MAX_SAMPLES);
    localparam logic [CFG_W-1:0] MINN = CFG_W'(2);
    localparam logic signed [PR_W-1:0] RND =
        {{(PR_W-T_BITS){1'b0}}, 1'b1, {(T_BITS-1){1'b0}}};
    localparam logic [TV_W-1:0] T_ONE = {1'b1, {T_BITS{1'b0}}};
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

    t_state                        r_state, n_state;
    logic [CFG_W-1:0]              r_cfg;
    logic signed [COORD_WIDTH-1:0] r_p0  [NAXES];
    logic signed [DF_W-1:0]        r_d10 [NAXES];
    logic signed [DF_W-1:0]        r_d21 [NAXES];
    logic signed [DF_W-1:0]        r_d32 [NAXES];
    logic signed [CF_W-1:0]        r_ca  [NAXES];
    logic signed [CF_W-1:0]        r_cb  [NAXES];
    logic signed [CF_W-1:0]        r_cc  [NAXES];
    logic [IDX_W-1:0]              r_den, r_idx;
    logic [CNT_W-1:0]              r_cnt;
    logic [TV_W-1:0]               r_qq, r_t, r_t2, r_t3;
    logic [R_W-1:0]                r_rr, r_r;
    logic [STEP_W-1:0]             r_step;
    logic signed [PR_W-1:0]        r_prod;
    t_dst                          r_pdst;
    logic [1:0]                    r_pax;
    logic                          r_pvld;
    logic signed [ACC_W-1:0]       r_acc [NAXES];
    logic                          r_out_valid;
    logic signed [COORD_WIDTH-1:0] r_out_pt [NAXES];
    logic [IDX_OUT_W-1:0]          r_out_idx;
    logic                          r_out_last;

    logic [CFG_W-1:0]              w_n;
    logic [IDX_W-1:0]              w_den;
    logic [D_W-1:0]                w_dvs;
    logic [R_W-1:0]                w_dshift;
    logic                          w_dge;
    t_op                           w_op;
    logic signed [CF_W-1:0]        w_a;
    logic [TV_W-1:0]               w_bu;
    logic signed [TV_W:0]          w_b;
    logic signed [PR_W-1:0]        w_mul;
    logic signed [ACC_W-1:0]       w_term;
    logic [R_W-1:0]                w_rsum;
    logic                          w_wrap;
    logic                          w_load;
    logic                          w_last;
    logic                          w_accept;
    logic signed [COORD_WIDTH-1:0] w_sat [NAXES];
    logic signed [CF_W-1:0]        w_e   [NAXES];

    // sample count and t step divisor
    always_comb begin
        priority if (r_cfg < MINN) begin
            w_n = MINN;
        end else if (r_cfg > MAXN) begin
            w_n = MAXN;
        end else begin
            w_n = r_cfg;
        end
    end

    assign w_den    = IDX_W'(w_n - CFG_W'(1));
    assign w_dvs    = {r_den, 1'b0};
    assign w_dshift = {r_rr[R_W-2:0], (r_cnt == CNT_W'(T_BITS + 1))};
    assign w_dge    = (w_dshift >= R_W'(w_dvs));
    assign w_rsum   = r_r + r_rr;
    assign w_wrap   = (w_rsum >= R_W'(w_dvs));
    assign w_last   = (r_idx == r_den);
    assign w_load   = (r_state == S_OUT) && (!r_out_valid || o_smp.ready);
    assign w_accept = i_pts.valid && i_pts.ready;

    // shared multiplier operands
    assign w_op = op_of(r_step);

    always_comb begin
        unique case (w_op.asel)
            A_T:     w_a = $signed(CF_W'(r_t));
            A_T2:    w_a = $signed(CF_W'(r_t2));
            A_C:     w_a = r_cc[w_op.axis];
            A_B:     w_a = r_cb[w_op.axis];
            A_A:     w_a = r_ca[w_op.axis];
            default: w_a = $signed(CF_W'(r_t));
        endcase
        unique case (w_op.bsel)
            B_T:     w_bu = r_t;
            B_T2:    w_bu = r_t2;
            B_T3:    w_bu = r_t3;
            default: w_bu = r_t;
        endcase
    end

    assign w_b    = $signed({1'b0, w_bu});
    assign w_mul  = w_a * w_b + RND;
    assign w_term = $signed(r_prod[PR_W-1:T_BITS]);

    always_comb begin
        for (int ax = 0; ax < NAXES; ax++) begin
            w_e[ax] = CF_W'(r_d21[ax]) - CF_W'(r_d10[ax]);
            priority if (r_acc[ax] > SAT_HI) begin
                w_sat[ax] = SAT_HI[COORD_WIDTH-1:0];
            end else if (r_acc[ax] < SAT_LO) begin
                w_sat[ax] = SAT_LO[COORD_WIDTH-1:0];
            end else begin
                w_sat[ax] = r_acc[ax][COORD_WIDTH-1:0];
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        i_pts.ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_pts.valid) n_state = S_COEF;
            end
            S_COEF: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == '0) n_state = S_MUL;
            end
            S_MUL: begin
                if (r_step == STEP_W'(NOPS)) n_state = S_OUT;
            end
            S_OUT: begin
                if (w_load) n_state = w_last ? S_IDLE : S_MUL;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CFG_W'(CFG_RESET);
            r_out_valid <= 1'b0;
            r_pvld      <= 1'b0;
        end else begin
            if (i_cfg_we) r_cfg <= i_cfg_wdata;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_smp.ready) begin
                r_out_valid <= 1'b0;
            end
            r_pvld <= (r_state == S_MUL) && (r_step < STEP_W'(NOPS));
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p0[0]  <= i_pts.start_x;
            r_p0[1]  <= i_pts.start_y;
            r_p0[2]  <= i_pts.start_z;
            r_d10[0] <= DF_W'(i_pts.ctrl1_x) - DF_W'(i_pts.start_x);
            r_d10[1] <= DF_W'(i_pts.ctrl1_y) - DF_W'(i_pts.start_y);
            r_d10[2] <= DF_W'(i_pts.ctrl1_z) - DF_W'(i_pts.start_z);
            r_d21[0] <= DF_W'(i_pts.ctrl2_x) - DF_W'(i_pts.ctrl1_x);
            r_d21[1] <= DF_W'(i_pts.ctrl2_y) - DF_W'(i_pts.ctrl1_y);
            r_d21[2] <= DF_W'(i_pts.ctrl2_z) - DF_W'(i_pts.ctrl1_z);
            r_d32[0] <= DF_W'(i_pts.end_x) - DF_W'(i_pts.ctrl2_x);
            r_d32[1] <= DF_W'(i_pts.end_y) - DF_W'(i_pts.ctrl2_y);
            r_d32[2] <= DF_W'(i_pts.end_z) - DF_W'(i_pts.ctrl2_z);
            r_den    <= w_den;
        end

        if (r_state == S_COEF) begin
            for (int ax = 0; ax < NAXES; ax++) begin
                r_cc[ax] <= (CF_W'(r_d10[ax]) <<< 1) + CF_W'(r_d10[ax]);
                r_cb[ax] <= (w_e[ax] <<< 1) + w_e[ax];
                r_ca[ax] <= CF_W'(r_d32[ax]) - (CF_W'(r_d21[ax]) <<< 1)
                            + CF_W'(r_d10[ax]);
            end
            r_cnt <= CNT_W'(DIV_STEPS - 1);
            r_rr  <= '0;
            r_qq  <= '0;
        end

        // restoring division of 2^(T_BITS+1) by twice the denominator
        if (r_state == S_DIV) begin
            r_rr  <= w_dge ? (w_dshift - R_W'(w_dvs)) : w_dshift;
            r_qq  <= {r_qq[TV_W-2:0], w_dge};
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                r_t    <= '0;
                r_r    <= R_W'(r_den);
                r_idx  <= '0;
                r_step <= '0;
                for (int ax = 0; ax < NAXES; ax++) begin
                    r_acc[ax] <= ACC_W'(r_p0[ax]);
                end
            end
        end

        if (r_state == S_MUL) begin
            r_step <= r_step + STEP_W'(1);
            if (r_step < STEP_W'(NOPS)) begin
                r_prod <= w_mul;
                r_pdst <= w_op.dst;
                r_pax  <= w_op.axis;
            end
        end

        if (r_pvld) begin
            unique case (r_pdst)
                D_T2:    r_t2 <= w_term[TV_W-1:0];
                D_T3:    r_t3 <= w_term[TV_W-1:0];
                D_ACC:   r_acc[r_pax] <= r_acc[r_pax] + w_term;
                default: r_t2 <= w_term[TV_W-1:0];
            endcase
        end

        if (w_load) begin
            r_out_pt   <= w_sat;
            r_out_idx  <= IDX_OUT_W'(r_idx);
            r_out_last <= w_last;
            if (!w_last) begin
                r_idx  <= r_idx + IDX_W'(1);
                r_step <= '0;
                for (int ax = 0; ax < NAXES; ax++) begin
                    r_acc[ax] <= ACC_W'(r_p0[ax]);
                end
                if (w_wrap) begin
                    r_r <= w_rsum - R_W'(w_dvs);
                    r_t <= r_t + r_qq + TV_W'(1);
                end else begin
                    r_r <= w_rsum;
                    r_t <= r_t + r_qq;
                end
            end
        end
    end

    assign o_smp.valid        = r_out_valid;
    assign o_smp.point_x      = r_out_pt[0];
    assign o_smp.point_y      = r_out_pt[1];
    assign o_smp.point_z      = r_out_pt[2];
    assign o_smp.sample_index = r_out_idx;
    assign o_smp.last_sample  = r_out_last;

    `ASSERT_NEXT(a_accept_to_coef, i_clk, i_rst_n, w_accept, r_state == S_COEF,
                 "accepted segment did not start coefficient setup")
    `ASSERT_IMPL(a_rem_below_div, i_clk, i_rst_n, r_state == S_MUL,
                 r_r < R_W'(w_dvs), "t step remainder out of range")
    `ASSERT_IMPL(a_last_t_one, i_clk, i_rst_n, w_load && w_last, r_t == T_ONE,
                 "last sample not at t of one")
    `ASSERT_IMPL(a_wb_in_mul, i_clk, i_rst_n, r_pvld,
                 r_state == S_MUL && r_step != '0, "product writeback outside multiply run")

endmodule
